// ===== hdl/hbr_pkg.sv =====
// Package for the HTTP byte-range parser: sizes, character codes,
// the scan phase type and the flag group passed from scanner to evaluator.
// No dependencies.
`timescale 1ns / 1ps

package hbr_pkg;

  localparam int unsigned DATA_W       = 64;
  localparam int unsigned OFFSET_W_DEF = 64;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned POS_W        = 3;

  localparam logic [POS_W-1:0]  PREFIX_LEN = 3'd6;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_FIRST  = 2'd1,
    PH_LAST   = 2'd2
  } phase_e;

  // Final parse status of one header, handed to the range evaluator.
  typedef struct packed {
    logic malformed;
    logic in_last;
    logic first_has;
    logic last_has;
  } scan_flags_t;

  // Expected character at each position of the "bytes=" prefix.
  function automatic logic [CHAR_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h79;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/hbr_if.sv =====
// Valid/ready channel interfaces for header characters and range results.
// Depends on hbr_pkg for the field widths.
`timescale 1ns / 1ps

interface hbr_in_if import hbr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] header_char;
  logic [DATA_W-1:0] resource_size;
  logic              end_of_header;

  modport source (output valid, header_char, resource_size, end_of_header, input ready);
  modport sink   (input valid, header_char, resource_size, end_of_header, output ready);
endinterface

interface hbr_out_if import hbr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              range_ok;
  logic [DATA_W-1:0] first_byte;
  logic [DATA_W-1:0] last_byte;

  modport source (output valid, range_ok, first_byte, last_byte, input ready);
  modport sink   (input valid, range_ok, first_byte, last_byte, output ready);
endinterface

// ===== hdl/hbr_scan.sv =====
// Character scanner: matches the prefix, accumulates both decimal numbers
// and snapshots the final parse state on the last character. Uses hbr_pkg.
`timescale 1ns / 1ps

module hbr_scan import hbr_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = OFFSET_W_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    beat_valid_i,
  input  logic [CHAR_W-1:0]       beat_char_i,
  input  logic                    beat_eoh_i,
  input  logic [OFFSET_WIDTH-1:0] beat_size_i,
  output logic                    snap_valid_o,
  output scan_flags_t             snap_flags_o,
  output logic [OFFSET_WIDTH-1:0] snap_first_o,
  output logic [OFFSET_WIDTH-1:0] snap_last_o,
  output logic [OFFSET_WIDTH-1:0] snap_size_o
);

  localparam int unsigned ACC_W = OFFSET_WIDTH + 4;

  phase_e                  phase_q, phase_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [OFFSET_WIDTH-1:0] first_q, first_d;
  logic [OFFSET_WIDTH-1:0] last_q, last_d;
  logic                    first_has_q, first_has_d;
  logic                    last_has_q, last_has_d;
  logic                    bad_q, bad_d;

  logic                    snap_valid_q;
  scan_flags_t             snap_flags_q;
  logic [OFFSET_WIDTH-1:0] snap_first_q, snap_last_q, snap_size_q;

  logic                    is_digit;
  logic [OFFSET_WIDTH-1:0] acc_sel;
  logic [ACC_W-1:0]        acc_ext;
  logic [ACC_W-1:0]        acc_next;
  logic                    acc_fits;

  assign is_digit = beat_char_i inside {[CHAR_ZERO:CHAR_NINE]};
  assign acc_sel  = (phase_q == PH_FIRST) ? first_q : last_q;
  assign acc_ext  = ACC_W'(acc_sel);
  // acc*10 + digit; it fits when nothing spills above the offset width.
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(beat_char_i[3:0]);
  assign acc_fits = (acc_next[ACC_W-1:OFFSET_WIDTH] == '0);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    first_d     = first_q;
    last_d      = last_q;
    first_has_d = first_has_q;
    last_has_d  = last_has_q;
    bad_d       = bad_q;
    if (!bad_q) begin
      if (beat_char_i == CHAR_COMMA) begin
        bad_d = 1'b1;
      end else begin
        case (phase_q)
          PH_PREFIX: begin
            if (pos_q < PREFIX_LEN && beat_char_i == prefix_char(pos_q)) begin
              pos_d = pos_q + 3'd1;
              if (pos_d == PREFIX_LEN) begin
                phase_d = PH_FIRST;
              end
            end else begin
              bad_d = 1'b1;
            end
          end
          PH_FIRST: begin
            if (beat_char_i == CHAR_DASH) begin
              phase_d = PH_LAST;
            end else if (is_digit && acc_fits) begin
              first_d     = acc_next[OFFSET_WIDTH-1:0];
              first_has_d = 1'b1;
            end else begin
              bad_d = 1'b1;
            end
          end
          PH_LAST: begin
            if (is_digit && acc_fits) begin
              last_d     = acc_next[OFFSET_WIDTH-1:0];
              last_has_d = 1'b1;
            end else begin
              bad_d = 1'b1;
            end
          end
          default: bad_d = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PREFIX;
      pos_q       <= '0;
      first_q     <= '0;
      last_q      <= '0;
      first_has_q <= 1'b0;
      last_has_q  <= 1'b0;
      bad_q       <= 1'b0;
    end else if (adv_i && beat_valid_i) begin
      if (beat_eoh_i) begin
        // The header is complete; the next beat starts a fresh one.
        phase_q     <= PH_PREFIX;
        pos_q       <= '0;
        first_q     <= '0;
        last_q      <= '0;
        first_has_q <= 1'b0;
        last_has_q  <= 1'b0;
        bad_q       <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        first_q     <= first_d;
        last_q      <= last_d;
        first_has_q <= first_has_d;
        last_has_q  <= last_has_d;
        bad_q       <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (adv_i) begin
      snap_valid_q <= beat_valid_i && beat_eoh_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      snap_flags_q.malformed <= bad_d;
      snap_flags_q.in_last   <= (phase_d == PH_LAST);
      snap_flags_q.first_has <= first_has_d;
      snap_flags_q.last_has  <= last_has_d;
      snap_first_q           <= first_d;
      snap_last_q            <= last_d;
      snap_size_q            <= beat_size_i;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_flags_o = snap_flags_q;
  assign snap_first_o = snap_first_q;
  assign snap_last_o  = snap_last_q;
  assign snap_size_o  = snap_size_q;

endmodule

// ===== hdl/hbr_eval.sv =====
// Range evaluator: turns the parsed numbers and the resource size into a
// checked, clamped byte range. Uses hbr_pkg for the flag struct.
`timescale 1ns / 1ps

module hbr_eval import hbr_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = OFFSET_W_DEF
) (
  input  scan_flags_t             flags_i,
  input  logic [OFFSET_WIDTH-1:0] first_i,
  input  logic [OFFSET_WIDTH-1:0] last_i,
  input  logic [OFFSET_WIDTH-1:0] size_i,
  output logic                    ok_o,
  output logic [OFFSET_WIDTH-1:0] start_o,
  output logic [OFFSET_WIDTH-1:0] end_o
);

  logic [OFFSET_WIDTH-1:0] size_m1;
  logic [OFFSET_WIDTH-1:0] suffix_len;
  logic [OFFSET_WIDTH-1:0] s, e;
  logic                    fail;

  assign size_m1    = size_i - OFFSET_WIDTH'(1);
  // A suffix longer than the resource covers the whole resource.
  assign suffix_len = (last_i < size_i) ? last_i : size_i;

  always_comb begin
    fail = flags_i.malformed || !flags_i.in_last || (size_i == '0);
    if (!flags_i.first_has) begin
      if (!flags_i.last_has || last_i == '0) begin
        fail = 1'b1;
      end
      s = size_i - suffix_len;
      e = size_m1;
    end else begin
      s = first_i;
      e = flags_i.last_has ? last_i : size_m1;
    end
    if (s > e || s >= size_i) begin
      fail = 1'b1;
    end
    ok_o    = !fail;
    start_o = fail ? '0 : s;
    end_o   = fail ? '0 : ((e > size_m1) ? size_m1 : e);
  end

endmodule

// ===== hdl/http_byte_range_parser.sv =====
// HTTP Range header parser, one character per beat, one result per header.
// The last character's beat passes the input register, scanner snapshot
// and output register to its result beat. Throughput: one character per
// cycle unless the sink stalls; they and the scanner state advance together.
// Reset (rst_ni low, asynchronous) clears the parse state and all valids.
// Depends on hbr_pkg, hbr_if, hbr_scan and hbr_eval.
`timescale 1ns / 1ps

module http_byte_range_parser import hbr_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = OFFSET_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hbr_in_if.sink    in_i,
  hbr_out_if.source out_o
);

  logic                    adv;
  logic                    s1_valid_q;
  logic [CHAR_W-1:0]       s1_char_q;
  logic                    s1_eoh_q;
  logic [OFFSET_WIDTH-1:0] s1_size_q;

  logic                    snap_valid;
  scan_flags_t             snap_flags;
  logic [OFFSET_WIDTH-1:0] snap_first, snap_last, snap_size;

  logic                    ev_ok;
  logic [OFFSET_WIDTH-1:0] ev_start, ev_end;

  logic                    out_valid_q;
  logic                    out_ok_q;
  logic [OFFSET_WIDTH-1:0] out_first_q, out_last_q;

  // The whole pipeline moves whenever the output register is free or drained.
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_i.valid;
      out_valid_q <= snap_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_char_q   <= in_i.header_char;
      s1_eoh_q    <= in_i.end_of_header;
      s1_size_q   <= in_i.resource_size[OFFSET_WIDTH-1:0];
      out_ok_q    <= ev_ok;
      out_first_q <= ev_start;
      out_last_q  <= ev_end;
    end
  end

  hbr_scan #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .beat_valid_i (s1_valid_q),
    .beat_char_i  (s1_char_q),
    .beat_eoh_i   (s1_eoh_q),
    .beat_size_i  (s1_size_q),
    .snap_valid_o (snap_valid),
    .snap_flags_o (snap_flags),
    .snap_first_o (snap_first),
    .snap_last_o  (snap_last),
    .snap_size_o  (snap_size)
  );

  hbr_eval #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_eval (
    .flags_i (snap_flags),
    .first_i (snap_first),
    .last_i  (snap_last),
    .size_i  (snap_size),
    .ok_o    (ev_ok),
    .start_o (ev_start),
    .end_o   (ev_end)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.range_ok   = out_ok_q;
  assign out_o.first_byte = DATA_W'(out_first_q);
  assign out_o.last_byte  = DATA_W'(out_last_q);

  // A rejected header reports an all-zero range.
  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_first_q == '0 && out_last_q == '0))
    else $error("rejected range carries nonzero offsets");

  // An accepted range is never inverted.
  a_ok_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ok_q) |-> (out_first_q <= out_last_q))
    else $error("accepted range has first byte past last byte");

  // A result waiting on the sink keeps its beat and the pipeline frozen.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_last_q)
      && $stable(s1_valid_q)))
    else $error("pipeline moved while the result was stalled");

endmodule
